// ===== hw/rtl/sidt_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps
package sidt_pkg;

  localparam int unsigned CharWidth = 6;

  localparam logic [CharWidth-1:0] AsciiZero  = 6'd48;
  localparam logic [CharWidth-1:0] AsciiMinus = 6'd45;
  localparam logic [3:0]           BcdAdjMin  = 4'd5;
  localparam logic [3:0]           BcdAdj     = 4'd3;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigit
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic idx_dec;
    logic emit_sign;
  } sidt_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic digit_zero;
    logic idx_zero;
    logic negative;
  } sidt_sts_t;

endpackage

// ===== hw/rtl/sidt_if.sv =====
// Valid/ready channel interfaces for the input value and the output text.
`timescale 1ns / 1ps
interface sidt_value_if #(
  parameter int unsigned ValueBits = 32
);
  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidt_text_if;
  logic       valid;
  logic       ready;
  logic [5:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== hw/rtl/sidt_ctrl.sv =====
// Sequencer for conversion, leading-zero skip and character emission.
`timescale 1ns / 1ps
module sidt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sidt_pkg::sidt_cmd_t cmd_o,
  input  sidt_pkg::sidt_sts_t sts_i
);
  import sidt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (sts_i.digit_zero && !sts_i.idx_zero) begin
          cmd_o.idx_dec = 1'b1;
        end else begin
          state_d = sts_i.negative ? StSign : StDigit;
        end
      end
      StSign: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_sign = 1'b1;
        if (out_ready_i) begin
          state_d = StDigit;
        end
      end
      StDigit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.idx_zero) begin
            state_d = StIdle;
          end else begin
            cmd_o.idx_dec = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ===== hw/rtl/sidt_datapath.sv =====
// Magnitude, bit-serial shift-and-add-3 BCD converter and character select.
`timescale 1ns / 1ps
module sidt_datapath #(
  parameter int unsigned ValueBits = 32,
  parameter int unsigned Digits    = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ValueBits-1:0] value_i,
  input  sidt_pkg::sidt_cmd_t  cmd_i,
  output sidt_pkg::sidt_sts_t  sts_o,
  output logic [5:0]           text_char_o,
  output logic                 last_char_o
);
  import sidt_pkg::*;

  localparam int unsigned CntW = $clog2(ValueBits);
  localparam int unsigned IdxW = $clog2(Digits);

  logic [ValueBits-1:0] mag_q, mag_d;
  logic [3:0]           digit_q [Digits];
  logic [3:0]           digit_d [Digits];
  logic [3:0]           adj     [Digits];
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 neg_q, neg_d;
  logic [3:0]           cur_digit;

  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      adj[i] = (digit_q[i] >= BcdAdjMin) ? digit_q[i] + BcdAdj : digit_q[i];
    end
  end

  always_comb begin
    mag_d = mag_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    neg_d = neg_q;
    for (int i = 0; i < Digits; i++) begin
      digit_d[i] = digit_q[i];
    end
    if (cmd_i.load) begin
      neg_d = value_i[ValueBits-1];
      mag_d = value_i[ValueBits-1] ? (~value_i + ValueBits'(1)) : value_i;
      cnt_d = CntW'(ValueBits - 1);
      idx_d = IdxW'(Digits - 1);
      for (int i = 0; i < Digits; i++) begin
        digit_d[i] = '0;
      end
    end else if (cmd_i.shift) begin
      mag_d      = {mag_q[ValueBits-2:0], 1'b0};
      cnt_d      = cnt_q - CntW'(1);
      digit_d[0] = {adj[0][2:0], mag_q[ValueBits-1]};
      for (int i = 1; i < Digits; i++) begin
        digit_d[i] = {adj[i][2:0], adj[i-1][3]};
      end
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
      cnt_q <= '0;
      idx_q <= '0;
      neg_q <= 1'b0;
      for (int i = 0; i < Digits; i++) begin
        digit_q[i] <= '0;
      end
    end else begin
      mag_q   <= mag_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      neg_q   <= neg_d;
      digit_q <= digit_d;
    end
  end

  assign cur_digit = digit_q[idx_q];

  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.digit_zero = (cur_digit == 4'd0);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.negative   = neg_q;

  assign text_char_o = cmd_i.emit_sign ? AsciiMinus : AsciiZero + {2'b00, cur_digit};
  assign last_char_o = !cmd_i.emit_sign && (idx_q == '0);

endmodule

// ===== hw/rtl/signed_int_to_decimal_text.sv =====
// Top level: signed integer to decimal ASCII text converter.
//
// Usage: value_i takes one signed two's complement integer per transaction.
// text_o returns its decimal text one character per transaction, most
// significant first: a '-' for negative values, then the digits with no
// leading zeros ("0" for zero). last_char marks the final character.
// Timing: the input transaction is taken in the idle state. The magnitude
// is converted to BCD by a bit-serial shift-and-add-3 loop, one bit per
// cycle. Leading zero digits are then skipped one per cycle, after which
// the sign, if any, and the digits are emitted, each character held until
// the receiver takes it. A new value is taken only after the last
// character of the previous one has been delivered.
// Reset: asynchronous, active low; returns the sequencer to idle, ready for
// a new value. While the receiver stalls, the current character is held.
`timescale 1ns / 1ps
module signed_int_to_decimal_text #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sidt_value_if.sink         value_i,
  sidt_text_if.source        text_o
);
  import sidt_pkg::*;

  localparam int unsigned Digits = (VALUE_BITS - 1) * 30103 / 100000 + 1;

  sidt_cmd_t cmd;
  sidt_sts_t sts;

  sidt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (value_i.valid),
    .in_ready_o  (value_i.ready),
    .out_valid_o (text_o.valid),
    .out_ready_i (text_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sidt_datapath #(
    .ValueBits (VALUE_BITS),
    .Digits    (Digits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .text_char_o (text_o.text_char),
    .last_char_o (text_o.last_char)
  );

endmodule
